// ===== rtl/pmhr_pkg.sv =====
// Shared types and constants for the pointer metadata hash registry.
// Used by every module under rtl/ except pmhr_queue; depends on nothing.
package pmhr_pkg;

    typedef enum logic [2:0] {
        OP_REGISTER  = 3'd0,
        OP_LOOKUP    = 3'd1,
        OP_SET_SIZE  = 3'd2,
        OP_SET_ELEMS = 3'd3,
        OP_REMOVE    = 3'd4,
        OP_REKEY     = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_ZERO_KEY  = 2'd3
    } status_t;

    // operation after classification by the front end
    typedef enum logic [2:0] {
        K_REGISTER,
        K_LOOKUP,
        K_SET_SIZE,
        K_SET_ELEMS,
        K_REMOVE,
        K_REKEY,
        K_ZERO_KEY
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] key;
        logic [63:0] new_key;
        logic [63:0] size;
        logic [63:0] elems;
    } item_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_PUSH
    } front_state_t;

    typedef enum logic [4:0] {
        B_CLEAR,
        B_IDLE,
        B_START,
        B_PRD,
        B_PCHK,
        B_PKEY,
        B_PDONE,
        B_SHRD,
        B_SHCHK,
        B_SHKEY,
        B_SHHASH,
        B_SHEND,
        B_AREM,
        B_LASTRD,
        B_LASTWR,
        B_LHASH,
        B_DATARD,
        B_DATACAP,
        B_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        STEP_FIND,
        STEP_INSERT,
        STEP_REMOVE,
        STEP_UPDATE
    } step_t;

    typedef enum logic [1:0] {
        HP_LO_LO,
        HP_HI_LO,
        HP_LO_HI,
        HP_MIX
    } hash_ph_t;

    localparam logic [63:0] HASH_MUL_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_MUL_MIX    = 64'hFF51AFD7ED558CCD;
    localparam int          HASH_XOR_SHIFT  = 33;
    localparam int          KEY_ALIGN_SHIFT = 4;

endpackage

// ===== rtl/pmhr_hash.sv =====
// Iterative key hash: shift, two 64-bit multiplies (three 32x32 partials
// each, one per cycle) and xor-shift mixing. Depends on pmhr_pkg.
module pmhr_hash #(
    parameter int IW = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [63:0]   key,
    output logic          done,
    output logic [IW-1:0] home
);
    import pmhr_pkg::*;

    logic [63:0] x_reg, x_next;
    logic [63:0] acc_reg, acc_next;
    hash_ph_t    ph_reg, ph_next;
    logic        round_reg, round_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [63:0] mul_c;
    logic [31:0] op_a, op_b;
    logic [63:0] prod;

    always_comb
    begin
        mul_c = round_reg ? HASH_MUL_MIX : HASH_MUL_GOLDEN;
        op_a  = (ph_reg == HP_HI_LO) ? x_reg[63:32] : x_reg[31:0];
        op_b  = (ph_reg == HP_LO_HI) ? mul_c[63:32] : mul_c[31:0];
        prod  = {32'd0, op_a} * {32'd0, op_b};
    end

    always_comb
    begin
        x_next     = x_reg;
        acc_next   = acc_reg;
        ph_next    = ph_reg;
        round_next = round_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (start)
        begin
            x_next     = key >> KEY_ALIGN_SHIFT;
            ph_next    = HP_LO_LO;
            round_next = 1'b0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            case (ph_reg)
                HP_LO_LO:
                begin
                    acc_next = prod;
                    ph_next  = HP_HI_LO;
                end
                HP_HI_LO:
                begin
                    acc_next = acc_reg + {prod[31:0], 32'd0};
                    ph_next  = HP_LO_HI;
                end
                HP_LO_HI:
                begin
                    acc_next = acc_reg + {prod[31:0], 32'd0};
                    ph_next  = HP_MIX;
                end
                HP_MIX:
                begin
                    x_next  = acc_reg ^ (acc_reg >> HASH_XOR_SHIFT);
                    ph_next = HP_LO_LO;
                    if (round_reg)
                    begin
                        run_next  = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        round_next = 1'b1;
                    end
                end
                default:
                begin
                    ph_next = HP_LO_LO;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= HP_LO_LO;
            round_reg <= 1'b0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ph_reg    <= ph_next;
            round_reg <= round_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign home = x_reg[IW-1:0];

endmodule

// ===== rtl/pmhr_queue.sv =====
// Two-beat queue between the front end and the engine.
// Generic payload width; depends on nothing.
module pmhr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    logic [WIDTH-1:0] data_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = data_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wp_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/pmhr_front.sv =====
// Front end: accepts input beats, classifies the operation and hashes
// key and new_key in parallel. Depends on pmhr_pkg and pmhr_hash.
module pmhr_front #(
    parameter int IW = 11
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     opcode,
    input  logic [63:0]                    key,
    input  logic [63:0]                    new_key,
    input  logic [63:0]                    size_in,
    input  logic [63:0]                    elems_in,
    input  logic                           hold,
    output logic                           push,
    input  logic                           full,
    output logic [$bits(pmhr_pkg::item_t)+2*IW-1:0] push_data
);
    import pmhr_pkg::*;

    front_state_t    state_reg, state_next;
    item_t           item_reg;
    logic [IW-1:0]   hk_reg, hn_reg;
    kind_t           kind_in;
    logic            accept;
    logic            hk_done, hn_done;
    logic [IW-1:0]   hk_home, hn_home;

    assign in_stall = (state_reg != F_IDLE) || hold;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        case (opcode)
            OP_REGISTER:  kind_in = K_REGISTER;
            OP_SET_SIZE:  kind_in = K_SET_SIZE;
            OP_SET_ELEMS: kind_in = K_SET_ELEMS;
            OP_REMOVE:    kind_in = K_REMOVE;
            OP_REKEY:     kind_in = (new_key == 64'd0) ? K_LOOKUP : K_REKEY;
            default:      kind_in = K_LOOKUP;
        endcase
        // rekey with a zero key still runs: it finds nothing, so new_key is appended
        if (kind_in != K_REKEY && key == 64'd0)
        begin
            kind_in = K_ZERO_KEY;
        end
    end

    pmhr_hash #(.IW(IW)) u_hash_key (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (key),
        .done  (hk_done),
        .home  (hk_home)
    );

    pmhr_hash #(.IW(IW)) u_hash_new (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key   (new_key),
        .done  (hn_done),
        .home  (hn_home)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_HASH;
                end
            end
            F_HASH:
            begin
                if (hk_done && hn_done)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push      = (state_reg == F_PUSH);
        push_data = {item_reg, hk_reg, hn_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.kind    <= kind_in;
            item_reg.key     <= key;
            item_reg.new_key <= new_key;
            item_reg.size    <= size_in;
            item_reg.elems   <= elems_in;
        end
        if (state_reg == F_HASH && hk_done && hn_done)
        begin
            hk_reg <= hk_home;
            hn_reg <= hn_home;
        end
    end

endmodule

// ===== rtl/pmhr_engine.sv =====
// Back end: slot stores, linear-probing index, backward-shift removal and
// the result register. Depends on pmhr_pkg and pmhr_hash.
module pmhr_engine #(
    parameter int CAPACITY    = 1024,
    parameter int INDEX_DEPTH = 2048
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      q_empty,
    input  logic [$bits(pmhr_pkg::item_t)+2*$clog2(INDEX_DEPTH)-1:0] q_data,
    output logic                                      q_pop,
    output logic                                      clearing,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [1:0]                                status,
    output logic [$clog2(CAPACITY)-1:0]               slot,
    output logic [63:0]                               size_out,
    output logic [63:0]                               elems_out,
    output logic [$clog2(CAPACITY+1)-1:0]             live_count
);
    import pmhr_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = CW;
    localparam int IW = $clog2(INDEX_DEPTH);
    localparam int NW = IW + 1;
    localparam int ITW = $bits(item_t);

    // memories
    logic [63:0]   key_mem   [CAPACITY];
    logic [63:0]   size_mem  [CAPACITY];
    logic [63:0]   elems_mem [CAPACITY];
    logic [EW-1:0] idx_mem   [INDEX_DEPTH];

    logic          key_we, size_we, elems_we, idx_we;
    logic [SW-1:0] key_wa, size_wa, elems_wa, key_ra, size_ra, elems_ra;
    logic [63:0]   key_wd, size_wd, elems_wd, key_rd, size_rd, elems_rd;
    logic [IW-1:0] idx_wa, idx_ra;
    logic [EW-1:0] idx_wd, idx_rd;

    back_state_t   state_reg, state_next;
    step_t         step_reg, step_next;
    kind_t         kind_reg, kind_next;
    logic [63:0]   key_reg, key_next, nkey_reg, nkey_next;
    logic [63:0]   size_reg, size_next, elems_reg, elems_next;
    logic [63:0]   cmpkey_reg, cmpkey_next;
    logic [IW-1:0] hkey_reg, hkey_next, hnew_reg, hnew_next;
    logic [CW-1:0] count_reg, count_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [IW-1:0] p_reg, p_next, hole_reg, hole_next, j_reg, j_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [NW-1:0] n_reg, n_next;
    logic [EW-1:0] e_reg, e_next, tgt_reg, tgt_next, newent_reg, newent_next;
    logic          hit_reg, hit_next, empty_reg, empty_next;
    logic          append_reg, append_next;
    status_t       res_status_reg, res_status_next;
    logic [SW-1:0] res_slot_reg, res_slot_next;
    logic [63:0]   res_size_reg, res_size_next, res_elems_reg, res_elems_next;
    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg, out_status_next;
    logic [SW-1:0] out_slot_reg, out_slot_next;
    logic [63:0]   out_size_reg, out_size_next, out_elems_reg, out_elems_next;
    logic [CW-1:0] out_live_reg, out_live_next;

    // shared hash unit for keys read back from the slot store
    logic          h_start, h_done;
    logic [63:0]   h_key;
    logic [IW-1:0] h_home;

    item_t         q_item;
    logic          e_nz, e_live, key_eq, probe_last, key_mode, reg_full;
    logic          is_last, dh_le;
    logic [IW-1:0] dh, dj;

    pmhr_hash #(.IW(IW)) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (h_start),
        .key   (h_key),
        .done  (h_done),
        .home  (h_home)
    );

    always_comb
    begin
        q_item     = q_data[2*IW +: ITW];
        e_nz       = (idx_rd != '0);
        e_live     = EW'(idx_rd - EW'(1)) < count_reg;
        key_eq     = (key_rd == cmpkey_reg);
        probe_last = (n_reg == NW'(INDEX_DEPTH - 1));
        key_mode   = (step_reg == STEP_FIND) || (step_reg == STEP_INSERT);
        reg_full   = (count_reg >= CW'(CAPACITY));
        is_last    = (CW'(slot_reg) == CW'(count_reg - CW'(1)));
        dh         = hole_reg - h_home;
        dj         = j_reg - h_home;
        dh_le      = (dh <= dj);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_reg == IW'(INDEX_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_START;
                end
            end
            B_START:
            begin
                case (kind_reg)
                    K_ZERO_KEY: state_next = B_EMIT;
                    K_REGISTER: state_next = reg_full ? B_EMIT : B_PRD;
                    default:    state_next = B_PRD;
                endcase
            end
            B_PRD:
            begin
                state_next = B_PCHK;
            end
            B_PCHK:
            begin
                if (!e_nz)
                begin
                    state_next = B_PDONE;
                end
                else if (key_mode && e_live)
                begin
                    state_next = B_PKEY;
                end
                else if (!key_mode && idx_rd == tgt_reg)
                begin
                    state_next = B_PDONE;
                end
                else
                begin
                    state_next = probe_last ? B_PDONE : B_PRD;
                end
            end
            B_PKEY:
            begin
                state_next = (key_eq || probe_last) ? B_PDONE : B_PRD;
            end
            B_PDONE:
            begin
                case (step_reg)
                    STEP_FIND:
                    begin
                        if (!hit_reg)
                        begin
                            state_next = (kind_reg == K_REKEY && !reg_full) ? B_PRD : B_EMIT;
                        end
                        else if (kind_reg == K_REMOVE
                                 || (kind_reg == K_REKEY && nkey_reg != key_reg))
                        begin
                            state_next = B_PRD;
                        end
                        else
                        begin
                            state_next = B_DATARD;
                        end
                    end
                    STEP_INSERT: state_next = B_DATARD;
                    STEP_REMOVE: state_next = hit_reg ? B_SHRD : B_AREM;
                    default:     state_next = B_EMIT;
                endcase
            end
            B_SHRD:
            begin
                state_next = B_SHCHK;
            end
            B_SHCHK:
            begin
                if (!e_nz || j_reg == hole_reg)
                begin
                    state_next = B_SHEND;
                end
                else if (e_live)
                begin
                    state_next = B_SHKEY;
                end
                else
                begin
                    state_next = probe_last ? B_SHEND : B_SHRD;
                end
            end
            B_SHKEY:
            begin
                state_next = B_SHHASH;
            end
            B_SHHASH:
            begin
                if (h_done)
                begin
                    state_next = probe_last ? B_SHEND : B_SHRD;
                end
            end
            B_SHEND:
            begin
                state_next = B_AREM;
            end
            B_AREM:
            begin
                if (kind_reg == K_REMOVE)
                begin
                    state_next = is_last ? B_EMIT : B_LASTRD;
                end
                else
                begin
                    state_next = B_PRD;
                end
            end
            B_LASTRD:
            begin
                state_next = B_LASTWR;
            end
            B_LASTWR:
            begin
                state_next = B_LHASH;
            end
            B_LHASH:
            begin
                if (h_done)
                begin
                    state_next = B_PRD;
                end
            end
            B_DATARD:
            begin
                state_next = B_DATACAP;
            end
            B_DATACAP:
            begin
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        step_next       = step_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        nkey_next       = nkey_reg;
        size_next       = size_reg;
        elems_next      = elems_reg;
        cmpkey_next     = cmpkey_reg;
        hkey_next       = hkey_reg;
        hnew_next       = hnew_reg;
        count_next      = count_reg;
        slot_next       = slot_reg;
        p_next          = p_reg;
        hole_next       = hole_reg;
        j_next          = j_reg;
        clr_next        = clr_reg;
        n_next          = n_reg;
        e_next          = e_reg;
        tgt_next        = tgt_reg;
        newent_next     = newent_reg;
        hit_next        = hit_reg;
        empty_next      = empty_reg;
        append_next     = append_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_size_next   = res_size_reg;
        res_elems_next  = res_elems_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_size_next   = out_size_reg;
        out_elems_next  = out_elems_reg;
        out_live_next   = out_live_reg;
        q_pop           = 1'b0;
        h_start         = 1'b0;
        h_key           = key_rd;
        key_we          = 1'b0;
        key_wa          = slot_reg;
        key_wd          = nkey_reg;
        key_ra          = '0;
        size_we         = 1'b0;
        size_wa         = slot_reg;
        size_wd         = size_reg;
        size_ra         = slot_reg;
        elems_we        = 1'b0;
        elems_wa        = slot_reg;
        elems_wd        = elems_reg;
        elems_ra        = slot_reg;
        idx_we          = 1'b0;
        idx_wa          = p_reg;
        idx_wd          = '0;
        idx_ra          = p_reg;

        case (state_reg)
            B_CLEAR:
            begin
                idx_we   = 1'b1;
                idx_wa   = clr_reg;
                clr_next = clr_reg + IW'(1);
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop       = 1'b1;
                    kind_next   = q_item.kind;
                    key_next    = q_item.key;
                    nkey_next   = q_item.new_key;
                    size_next   = q_item.size;
                    elems_next  = q_item.elems;
                    hkey_next   = q_data[2*IW-1:IW];
                    hnew_next   = q_data[IW-1:0];
                    append_next = 1'b0;
                end
            end
            B_START:
            begin
                res_slot_next  = '0;
                res_size_next  = '0;
                res_elems_next = '0;
                p_next         = hkey_reg;
                n_next         = '0;
                cmpkey_next    = key_reg;
                step_next      = STEP_FIND;
                case (kind_reg)
                    K_ZERO_KEY:
                    begin
                        res_status_next = ST_ZERO_KEY;
                    end
                    K_REGISTER:
                    begin
                        res_status_next = ST_FULL;
                        if (!reg_full)
                        begin
                            // fill the new slot first, then index it
                            key_we      = 1'b1;
                            key_wa      = count_reg[SW-1:0];
                            key_wd      = key_reg;
                            size_we     = 1'b1;
                            size_wa     = count_reg[SW-1:0];
                            elems_we    = 1'b1;
                            elems_wa    = count_reg[SW-1:0];
                            slot_next   = count_reg[SW-1:0];
                            append_next = 1'b1;
                            step_next   = STEP_INSERT;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                endcase
            end
            B_PCHK:
            begin
                e_next = idx_rd;
                key_ra = SW'(idx_rd - EW'(1));
                if (!e_nz)
                begin
                    hit_next   = 1'b0;
                    empty_next = 1'b1;
                end
                else if (key_mode && e_live)
                begin
                    // key compare happens next cycle
                end
                else if (!key_mode && idx_rd == tgt_reg)
                begin
                    hit_next   = 1'b1;
                    empty_next = 1'b0;
                end
                else if (probe_last)
                begin
                    hit_next   = 1'b0;
                    empty_next = 1'b0;
                end
                else
                begin
                    n_next = n_reg + NW'(1);
                    p_next = p_reg + IW'(1);
                end
            end
            B_PKEY:
            begin
                if (key_eq)
                begin
                    hit_next   = 1'b1;
                    empty_next = 1'b0;
                end
                else if (probe_last)
                begin
                    hit_next   = 1'b0;
                    empty_next = 1'b0;
                end
                else
                begin
                    n_next = n_reg + NW'(1);
                    p_next = p_reg + IW'(1);
                end
            end
            B_PDONE:
            begin
                case (step_reg)
                    STEP_FIND:
                    begin
                        if (!hit_reg)
                        begin
                            if (kind_reg == K_REKEY)
                            begin
                                res_status_next = ST_FULL;
                                if (!reg_full)
                                begin
                                    // absent key: append new_key as a fresh block
                                    key_we      = 1'b1;
                                    key_wa      = count_reg[SW-1:0];
                                    key_wd      = nkey_reg;
                                    size_we     = 1'b1;
                                    size_wa     = count_reg[SW-1:0];
                                    elems_we    = 1'b1;
                                    elems_wa    = count_reg[SW-1:0];
                                    elems_wd    = '0;
                                    slot_next   = count_reg[SW-1:0];
                                    append_next = 1'b1;
                                    p_next      = hnew_reg;
                                    n_next      = '0;
                                    cmpkey_next = nkey_reg;
                                    step_next   = STEP_INSERT;
                                end
                            end
                        end
                        else
                        begin
                            slot_next = SW'(e_reg - EW'(1));
                            p_next    = hkey_reg;
                            n_next    = '0;
                            tgt_next  = e_reg;
                            step_next = STEP_REMOVE;
                        end
                    end
                    STEP_INSERT:
                    begin
                        if (empty_reg || hit_reg)
                        begin
                            idx_we = 1'b1;
                            idx_wd = EW'(slot_reg) + EW'(1);
                        end
                        if (append_reg)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    STEP_REMOVE:
                    begin
                        hole_next = p_reg;
                        j_next    = p_reg + IW'(1);
                        n_next    = NW'(1);
                    end
                    default:
                    begin
                        // last slot has moved into the hole: repoint its entry
                        if (hit_reg)
                        begin
                            idx_we = 1'b1;
                            idx_wd = newent_reg;
                        end
                        count_next      = count_reg - CW'(1);
                        res_status_next = ST_OK;
                        res_slot_next   = slot_reg;
                    end
                endcase
            end
            B_SHRD:
            begin
                idx_ra = j_reg;
            end
            B_SHCHK:
            begin
                e_next = idx_rd;
                key_ra = SW'(idx_rd - EW'(1));
                if (!e_nz || j_reg == hole_reg || e_live || probe_last)
                begin
                    // stop, or go fetch the entry's key
                end
                else
                begin
                    n_next = n_reg + NW'(1);
                    j_next = j_reg + IW'(1);
                end
            end
            B_SHKEY:
            begin
                h_start = 1'b1;
                h_key   = key_rd;
            end
            B_SHHASH:
            begin
                if (h_done)
                begin
                    if (dh_le)
                    begin
                        idx_we    = 1'b1;
                        idx_wa    = hole_reg;
                        idx_wd    = e_reg;
                        hole_next = j_reg;
                    end
                    if (!probe_last)
                    begin
                        n_next = n_reg + NW'(1);
                        j_next = j_reg + IW'(1);
                    end
                end
            end
            B_SHEND:
            begin
                idx_we = 1'b1;
                idx_wa = hole_reg;
                idx_wd = '0;
            end
            B_AREM:
            begin
                if (kind_reg == K_REMOVE)
                begin
                    res_status_next = ST_OK;
                    res_slot_next   = slot_reg;
                    if (is_last)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                else
                begin
                    key_we      = 1'b1;
                    key_wd      = nkey_reg;
                    p_next      = hnew_reg;
                    n_next      = '0;
                    cmpkey_next = nkey_reg;
                    step_next   = STEP_INSERT;
                end
            end
            B_LASTRD:
            begin
                key_ra   = SW'(count_reg - CW'(1));
                size_ra  = SW'(count_reg - CW'(1));
                elems_ra = SW'(count_reg - CW'(1));
            end
            B_LASTWR:
            begin
                key_we   = 1'b1;
                key_wd   = key_rd;
                size_we  = 1'b1;
                size_wd  = size_rd;
                elems_we = 1'b1;
                elems_wd = elems_rd;
                h_start  = 1'b1;
                h_key    = key_rd;
            end
            B_LHASH:
            begin
                if (h_done)
                begin
                    p_next      = h_home;
                    n_next      = '0;
                    tgt_next    = count_reg;
                    newent_next = EW'(slot_reg) + EW'(1);
                    step_next   = STEP_UPDATE;
                end
            end
            B_DATARD:
            begin
                if (kind_reg == K_SET_SIZE || kind_reg == K_REKEY)
                begin
                    size_we = 1'b1;
                end
                if (kind_reg == K_SET_ELEMS)
                begin
                    elems_we = 1'b1;
                end
            end
            B_DATACAP:
            begin
                res_status_next = ST_OK;
                res_slot_next   = slot_reg;
                res_size_next   = (kind_reg == K_SET_SIZE || kind_reg == K_REKEY)
                                  ? size_reg : size_rd;
                res_elems_next  = (kind_reg == K_SET_ELEMS) ? elems_reg : elems_rd;
            end
            B_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_size_next   = res_size_reg;
                    out_elems_next  = res_elems_reg;
                    out_live_next   = count_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            step_reg      <= STEP_FIND;
            clr_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            empty_reg     <= 1'b0;
            append_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            empty_reg     <= empty_next;
            append_reg    <= append_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        nkey_reg       <= nkey_next;
        size_reg       <= size_next;
        elems_reg      <= elems_next;
        cmpkey_reg     <= cmpkey_next;
        hkey_reg       <= hkey_next;
        hnew_reg       <= hnew_next;
        slot_reg       <= slot_next;
        p_reg          <= p_next;
        hole_reg       <= hole_next;
        j_reg          <= j_next;
        n_reg          <= n_next;
        e_reg          <= e_next;
        tgt_reg        <= tgt_next;
        newent_reg     <= newent_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_size_reg   <= res_size_next;
        res_elems_reg  <= res_elems_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_size_reg   <= out_size_next;
        out_elems_reg  <= out_elems_next;
        out_live_reg   <= out_live_next;
    end

    // memories: one write and one registered read port each
    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        key_rd <= key_mem[key_ra];
    end

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_wa] <= size_wd;
        end
        size_rd <= size_mem[size_ra];
    end

    always_ff @(posedge clk)
    begin
        if (elems_we)
        begin
            elems_mem[elems_wa] <= elems_wd;
        end
        elems_rd <= elems_mem[elems_ra];
    end

    always_ff @(posedge clk)
    begin
        if (idx_we)
        begin
            idx_mem[idx_wa] <= idx_wd;
        end
        idx_rd <= idx_mem[idx_ra];
    end

    assign clearing   = (state_reg == B_CLEAR);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign slot       = out_slot_reg;
    assign size_out   = out_size_reg;
    assign elems_out  = out_elems_reg;
    assign live_count = out_live_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("slot count above capacity");

    a_clear_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !q_pop)
        else $error("queue popped during index clear");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |->
        (out_slot_reg == '0 && out_size_reg == '0 && out_elems_reg == '0))
        else $error("failed result carries data");

    a_live_match: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_live_reg == count_reg))
        else $error("live count in result differs from slot count");

endmodule

// ===== rtl/pointer_metadata_hash_registry_core.sv =====
// Pointer metadata hash registry. Per beat: the front end accepts it, hashes
// key and new_key in two parallel hash units and pushes it; the engine probes
// the index; a removal adds, for each live entry scanned in the backward
// shift, a key read and a pass through the engine's hash unit.
// A two-beat queue overlaps front end and engine; results sit in an output register.
// Reset: the whole index table is cleared with in_stall held high.
module pointer_metadata_hash_registry_core #(
    parameter int CAPACITY    = 1024,
    parameter int INDEX_DEPTH = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    opcode,
    input  logic [63:0]                   key,
    input  logic [63:0]                   new_key,
    input  logic [63:0]                   size_in,
    input  logic [63:0]                   elems_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    status,
    output logic [$clog2(CAPACITY)-1:0]   slot,
    output logic [63:0]                   size_out,
    output logic [63:0]                   elems_out,
    output logic [$clog2(CAPACITY+1)-1:0] live_count
);
    import pmhr_pkg::*;

    localparam int IW = $clog2(INDEX_DEPTH);
    localparam int QW = $bits(item_t) + 2 * IW;

    // front end -> queue -> engine
    logic          push, full, pop, empty, clearing;
    logic [QW-1:0] push_data, pop_data;

    // Front end takes a beat only when idle and the index clear is done.
    pmhr_front #(.IW(IW)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .key       (key),
        .new_key   (new_key),
        .size_in   (size_in),
        .elems_in  (elems_in),
        .hold      (clearing),
        .push      (push),
        .full      (full),
        .push_data (push_data)
    );

    // Classified, hashed beats wait here while the engine is busy.
    pmhr_queue #(.WIDTH(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    // Engine: stores, probing index, removal and result register.
    pmhr_engine #(
        .CAPACITY    (CAPACITY),
        .INDEX_DEPTH (INDEX_DEPTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (empty),
        .q_data     (pop_data),
        .q_pop      (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot       (slot),
        .size_out   (size_out),
        .elems_out  (elems_out),
        .live_count (live_count)
    );

endmodule
